// File: rtl/bfst_pkg.sv
// shared types, codes and widths for the beacon sighting table
// no dependencies; used by every module of the block
package bfst_pkg;

	// default table and list sizes
	localparam int SIGHT_SLOTS_DEF      = 8;
	localparam int ALLOW_ADDR_SLOTS_DEF = 8;
	localparam int ALLOW_PAIR_SLOTS_DEF = 8;

	// field widths
	localparam int FUNC_W     = 2;
	localparam int ADDR_W     = 48;
	localparam int UUID_W     = 64;
	localparam int ID_W       = 16;
	localparam int RSSI_W     = 8;
	localparam int TIME_W     = 32;
	localparam int ENTRY_W    = 3;
	localparam int CNT_W      = 4;
	localparam int SLOT_W     = 3;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// item function codes
	localparam logic [FUNC_W-1:0] FUNC_SIGHTING   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ALLOW_ADDR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ALLOW_PAIR = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UUID_HIGH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UUID_LOW   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ADDR_COUNT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_COUNT = 2'd3;

	// slot status codes
	localparam logic [STATUS_W-1:0] ST_UPDATED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FILLED    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERWROTE = 2'd2;

	// which table the walk is reading
	typedef enum logic [1:0] {
		SEL_ADDR,
		SEL_PAIR,
		SEL_SLOT
	} walk_sel_t;

	// controller to datapath
	typedef struct packed {
		logic      capture;
		logic      wr_allow_addr;
		logic      wr_allow_pair;
		logic      clr;
		logic      scan;
		walk_sel_t sel;
		logic      commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic uuid_ok;
		logic lists_empty;
		logic hit;
		logic walk_end;
	} dp_stat_t;

	// address width of a store of the given depth
	function automatic int addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	function automatic int max3(input int a, input int b, input int c);
		int m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

endpackage

// File: rtl/bfst_ram.sv
// generic single write, single read ram with registered read data
// depends on bfst_pkg for the address width helper
module bfst_ram #(
	parameter int W = 8,
	parameter int D = 8
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [bfst_pkg::addr_w(D)-1:0] waddr,
	input  logic [W-1:0]                   wdata,
	input  logic                           re,
	input  logic [bfst_pkg::addr_w(D)-1:0] raddr,
	output logic [W-1:0]                   rdata
);

	logic [W-1:0] mem [D];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/bfst_ctrl.sv
// controller: sequences uuid check, allow list walks, slot walk and commit
// depends on bfst_pkg for command and status structs
module bfst_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [bfst_pkg::FUNC_W-1:0]     func,
	input  bfst_pkg::dp_stat_t              stat,
	output logic                            busy,
	output bfst_pkg::dp_cmd_t               cmd
);

	typedef enum logic [2:0] {
		IDLE,
		CHECK,
		SCAN_ADDR,
		SCAN_PAIR,
		SCAN_SLOT,
		COMMIT
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.sel = bfst_pkg::SEL_SLOT;
		unique case (state_q)
			IDLE: begin
				if (start) begin
					cmd.capture       = 1'b1;
					cmd.wr_allow_addr = (func == bfst_pkg::FUNC_ALLOW_ADDR);
					cmd.wr_allow_pair = (func == bfst_pkg::FUNC_ALLOW_PAIR);
					if (func == bfst_pkg::FUNC_SIGHTING) begin
						state_d = CHECK;
					end
				end
			end
			CHECK: begin
				cmd.clr = 1'b1;
				if (!stat.uuid_ok) begin
					state_d = IDLE;
				end else if (stat.lists_empty) begin
					state_d = SCAN_SLOT;
				end else begin
					state_d = SCAN_ADDR;
				end
			end
			SCAN_ADDR: begin
				cmd.scan = 1'b1;
				cmd.sel  = bfst_pkg::SEL_ADDR;
				if (stat.hit) begin
					cmd.clr = 1'b1;
					state_d = SCAN_SLOT;
				end else if (stat.walk_end) begin
					cmd.clr = 1'b1;
					state_d = SCAN_PAIR;
				end
			end
			SCAN_PAIR: begin
				cmd.scan = 1'b1;
				cmd.sel  = bfst_pkg::SEL_PAIR;
				if (stat.hit) begin
					cmd.clr = 1'b1;
					state_d = SCAN_SLOT;
				end else if (stat.walk_end) begin
					state_d = IDLE;
				end
			end
			SCAN_SLOT: begin
				cmd.scan = 1'b1;
				cmd.sel  = bfst_pkg::SEL_SLOT;
				if (stat.hit || stat.walk_end) begin
					state_d = COMMIT;
				end
			end
			COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = IDLE;
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != IDLE);

endmodule

// File: rtl/bfst_dp.sv
// datapath: config registers, captured item, allow list and slot rams, walk
// depends on bfst_pkg and bfst_ram
module bfst_dp #(
	parameter int SIGHT_SLOTS      = bfst_pkg::SIGHT_SLOTS_DEF,
	parameter int ALLOW_ADDR_SLOTS = bfst_pkg::ALLOW_ADDR_SLOTS_DEF,
	parameter int ALLOW_PAIR_SLOTS = bfst_pkg::ALLOW_PAIR_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bfst_pkg::dp_cmd_t                  cmd,
	output bfst_pkg::dp_stat_t                 stat,
	// configuration writes
	input  logic                               cfg_we,
	input  logic [bfst_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfst_pkg::CFG_DATA_W-1:0]    cfg_data,
	// item fields
	input  logic [bfst_pkg::ADDR_W-1:0]        device_address,
	input  logic [bfst_pkg::UUID_W-1:0]        uuid_high,
	input  logic [bfst_pkg::UUID_W-1:0]        uuid_low,
	input  logic [bfst_pkg::ID_W-1:0]          major_id,
	input  logic [bfst_pkg::ID_W-1:0]          minor_id,
	input  logic signed [bfst_pkg::RSSI_W-1:0] signal_strength,
	input  logic [bfst_pkg::TIME_W-1:0]        time_ms,
	input  logic [bfst_pkg::ENTRY_W-1:0]       entry_index,
	// result
	output logic                               result_valid,
	output logic [bfst_pkg::SLOT_W-1:0]        slot_index,
	output logic [bfst_pkg::STATUS_W-1:0]      slot_status,
	output logic [bfst_pkg::ADDR_W-1:0]        out_address,
	output logic [bfst_pkg::UUID_W-1:0]        out_uuid_high,
	output logic [bfst_pkg::UUID_W-1:0]        out_uuid_low,
	output logic [bfst_pkg::ID_W-1:0]          out_major,
	output logic [bfst_pkg::ID_W-1:0]          out_minor,
	output logic signed [bfst_pkg::RSSI_W-1:0] out_strength,
	output logic [bfst_pkg::TIME_W-1:0]        last_seen
);

	localparam int MAXN = bfst_pkg::max3(SIGHT_SLOTS, ALLOW_ADDR_SLOTS, ALLOW_PAIR_SLOTS);
	localparam int IW   = $clog2(MAXN + 1);
	localparam int SAW  = bfst_pkg::addr_w(SIGHT_SLOTS);
	localparam int AAW  = bfst_pkg::addr_w(ALLOW_ADDR_SLOTS);
	localparam int PAW  = bfst_pkg::addr_w(ALLOW_PAIR_SLOTS);
	localparam int PW   = 2 * bfst_pkg::ID_W;

	// configuration registers
	logic [bfst_pkg::UUID_W-1:0] cfg_uuid_high_q;
	logic [bfst_pkg::UUID_W-1:0] cfg_uuid_low_q;
	logic [bfst_pkg::CNT_W-1:0]  cfg_addr_cnt_q;
	logic [bfst_pkg::CNT_W-1:0]  cfg_pair_cnt_q;

	// captured sighting
	logic [bfst_pkg::ADDR_W-1:0]        addr_q;
	logic [bfst_pkg::UUID_W-1:0]        uuid_high_q;
	logic [bfst_pkg::UUID_W-1:0]        uuid_low_q;
	logic [bfst_pkg::ID_W-1:0]          major_q;
	logic [bfst_pkg::ID_W-1:0]          minor_q;
	logic signed [bfst_pkg::RSSI_W-1:0] rssi_q;
	logic [bfst_pkg::TIME_W-1:0]        time_q;

	// walk state
	logic [IW-1:0] idx_q;
	logic [IW-1:0] cmp_idx_q;
	logic          cmp_q;
	logic [IW-1:0] lim;
	logic [IW-1:0] lim_addr;
	logic [IW-1:0] lim_pair;
	logic          issue;
	logic          hit;

	// slot tracking
	logic [SIGHT_SLOTS-1:0] slot_valid_q;
	logic [SAW-1:0]         cmp_slot;
	logic                   found_q;
	logic [SAW-1:0]         found_idx_q;
	logic                   empty_q;
	logic [SAW-1:0]         empty_idx_q;
	logic [SAW-1:0]         chosen;
	logic [bfst_pkg::STATUS_W-1:0] status;

	// ram ports
	logic                        allow_addr_we;
	logic                        allow_pair_we;
	logic [bfst_pkg::ADDR_W-1:0] rd_allow_addr;
	logic [PW-1:0]               rd_allow_pair;
	logic [bfst_pkg::ADDR_W-1:0] rd_slot_addr;

	// result registers
	logic                               result_valid_q;
	logic [bfst_pkg::SLOT_W-1:0]        slot_index_q;
	logic [bfst_pkg::STATUS_W-1:0]      slot_status_q;
	logic [bfst_pkg::ADDR_W-1:0]        out_address_q;
	logic [bfst_pkg::UUID_W-1:0]        out_uuid_high_q;
	logic [bfst_pkg::UUID_W-1:0]        out_uuid_low_q;
	logic [bfst_pkg::ID_W-1:0]          out_major_q;
	logic [bfst_pkg::ID_W-1:0]          out_minor_q;
	logic signed [bfst_pkg::RSSI_W-1:0] out_strength_q;
	logic [bfst_pkg::TIME_W-1:0]        last_seen_q;

	// configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_uuid_high_q <= '0;
			cfg_uuid_low_q  <= '0;
			cfg_addr_cnt_q  <= '0;
			cfg_pair_cnt_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bfst_pkg::REG_UUID_HIGH:  cfg_uuid_high_q <= cfg_data;
				bfst_pkg::REG_UUID_LOW:   cfg_uuid_low_q  <= cfg_data;
				bfst_pkg::REG_ADDR_COUNT: cfg_addr_cnt_q  <= cfg_data[bfst_pkg::CNT_W-1:0];
				bfst_pkg::REG_PAIR_COUNT: cfg_pair_cnt_q  <= cfg_data[bfst_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// item capture on accept
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q      <= device_address;
			uuid_high_q <= uuid_high;
			uuid_low_q  <= uuid_low;
			major_q     <= major_id;
			minor_q     <= minor_id;
			rssi_q      <= signal_strength;
			time_q      <= time_ms;
		end
	end

	// allow list writes, indexes past the list are dropped
	assign allow_addr_we = cmd.wr_allow_addr &&
		(32'(entry_index) < 32'(ALLOW_ADDR_SLOTS));
	assign allow_pair_we = cmd.wr_allow_pair &&
		(32'(entry_index) < 32'(ALLOW_PAIR_SLOTS));

	// list lengths saturated to the list sizes
	assign lim_addr = (32'(cfg_addr_cnt_q) > 32'(ALLOW_ADDR_SLOTS)) ?
		IW'(ALLOW_ADDR_SLOTS) : IW'(cfg_addr_cnt_q);
	assign lim_pair = (32'(cfg_pair_cnt_q) > 32'(ALLOW_PAIR_SLOTS)) ?
		IW'(ALLOW_PAIR_SLOTS) : IW'(cfg_pair_cnt_q);

	always_comb begin
		case (cmd.sel)
			bfst_pkg::SEL_ADDR: lim = lim_addr;
			bfst_pkg::SEL_PAIR: lim = lim_pair;
			default:            lim = IW'(SIGHT_SLOTS);
		endcase
	end

	assign issue    = cmd.scan && (idx_q != lim);
	assign cmp_slot = cmp_idx_q[SAW-1:0];

	// compare of the entry read last cycle
	always_comb begin
		case (cmd.sel)
			bfst_pkg::SEL_ADDR: hit = cmp_q && (rd_allow_addr == addr_q);
			bfst_pkg::SEL_PAIR: hit = cmp_q && (rd_allow_pair == {major_q, minor_q});
			default:            hit = cmp_q && slot_valid_q[cmp_slot] &&
				(rd_slot_addr == addr_q);
		endcase
	end

	// walk counter, one ram read per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			cmp_q     <= 1'b0;
			cmp_idx_q <= '0;
		end else if (cmd.clr) begin
			idx_q <= '0;
			cmp_q <= 1'b0;
		end else begin
			cmp_q <= issue;
			if (issue) begin
				idx_q     <= idx_q + 1'b1;
				cmp_idx_q <= idx_q;
			end
		end
	end

	// first matching slot and first empty slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			found_idx_q <= '0;
			empty_q     <= 1'b0;
			empty_idx_q <= '0;
		end else if (cmd.clr) begin
			found_q <= 1'b0;
			empty_q <= 1'b0;
		end else if (cmd.scan && cmd.sel == bfst_pkg::SEL_SLOT && cmp_q) begin
			if (hit && !found_q) begin
				found_q     <= 1'b1;
				found_idx_q <= cmp_slot;
			end
			if (!slot_valid_q[cmp_slot] && !empty_q) begin
				empty_q     <= 1'b1;
				empty_idx_q <= cmp_slot;
			end
		end
	end

	// slot choice: match, else first empty, else slot zero
	always_comb begin
		if (found_q) begin
			chosen = found_idx_q;
			status = bfst_pkg::ST_UPDATED;
		end else if (empty_q) begin
			chosen = empty_idx_q;
			status = bfst_pkg::ST_FILLED;
		end else begin
			chosen = '0;
			status = bfst_pkg::ST_OVERWROTE;
		end
	end

	// slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (cmd.commit) begin
			slot_valid_q[chosen] <= 1'b1;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= cmd.commit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			slot_index_q    <= bfst_pkg::SLOT_W'(chosen);
			slot_status_q   <= status;
			out_address_q   <= addr_q;
			out_uuid_high_q <= uuid_high_q;
			out_uuid_low_q  <= uuid_low_q;
			out_major_q     <= major_q;
			out_minor_q     <= minor_q;
			out_strength_q  <= rssi_q;
			last_seen_q     <= time_q;
		end
	end

	// address allow list
	bfst_ram #(.W(bfst_pkg::ADDR_W), .D(ALLOW_ADDR_SLOTS)) u_allow_addr (
		.clk   (clk),
		.we    (allow_addr_we),
		.waddr (AAW'(entry_index)),
		.wdata (device_address),
		.re    (issue && cmd.sel == bfst_pkg::SEL_ADDR),
		.raddr (idx_q[AAW-1:0]),
		.rdata (rd_allow_addr)
	);

	// major/minor allow list
	bfst_ram #(.W(PW), .D(ALLOW_PAIR_SLOTS)) u_allow_pair (
		.clk   (clk),
		.we    (allow_pair_we),
		.waddr (PAW'(entry_index)),
		.wdata ({major_id, minor_id}),
		.re    (issue && cmd.sel == bfst_pkg::SEL_PAIR),
		.raddr (idx_q[PAW-1:0]),
		.rdata (rd_allow_pair)
	);

	// sighting table addresses
	bfst_ram #(.W(bfst_pkg::ADDR_W), .D(SIGHT_SLOTS)) u_slot_addr (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (chosen),
		.wdata (addr_q),
		.re    (issue && cmd.sel == bfst_pkg::SEL_SLOT),
		.raddr (idx_q[SAW-1:0]),
		.rdata (rd_slot_addr)
	);

	// status to the controller
	assign stat.uuid_ok     = (uuid_high_q == cfg_uuid_high_q) &&
		(uuid_low_q == cfg_uuid_low_q);
	assign stat.lists_empty = (cfg_addr_cnt_q == '0) && (cfg_pair_cnt_q == '0);
	assign stat.hit         = hit;
	assign stat.walk_end    = (idx_q == lim);

	assign result_valid  = result_valid_q;
	assign slot_index    = slot_index_q;
	assign slot_status   = slot_status_q;
	assign out_address   = out_address_q;
	assign out_uuid_high = out_uuid_high_q;
	assign out_uuid_low  = out_uuid_low_q;
	assign out_major     = out_major_q;
	assign out_minor     = out_minor_q;
	assign out_strength  = out_strength_q;
	assign last_seen     = last_seen_q;

endmodule

// File: rtl/beacon_filter_sighting_table.sv
// top level of the beacon accept list filter and sighting table
// depends on bfst_pkg, bfst_ctrl, bfst_dp and bfst_ram
//
// A beat is taken when start is high and busy is low. Allow list writes
// (func 1 and 2) and the unused func code finish in the accepting cycle and
// busy never rises, so the next beat can follow right away. A sighting holds
// busy through a uuid check, then walks the address list, the major/minor
// list and the table, then commits; it ends early when the uuid
// mismatches, both lists are empty or a list hits early. The walk
// reads one entry a cycle through the single read port of each ram. The
// result is shown for exactly one cycle on result_valid, in the cycle after
// commit, while busy is already low; the receiver cannot hold it off.
// Configuration writes are always taken when busy is low.
module beacon_filter_sighting_table #(
	parameter int SIGHT_SLOTS      = bfst_pkg::SIGHT_SLOTS_DEF,
	parameter int ALLOW_ADDR_SLOTS = bfst_pkg::ALLOW_ADDR_SLOTS_DEF,
	parameter int ALLOW_PAIR_SLOTS = bfst_pkg::ALLOW_PAIR_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// command side
	input  logic                               start,
	output logic                               busy,
	input  logic [bfst_pkg::FUNC_W-1:0]        func,
	input  logic [bfst_pkg::ADDR_W-1:0]        device_address,
	input  logic [bfst_pkg::UUID_W-1:0]        uuid_high,
	input  logic [bfst_pkg::UUID_W-1:0]        uuid_low,
	input  logic [bfst_pkg::ID_W-1:0]          major_id,
	input  logic [bfst_pkg::ID_W-1:0]          minor_id,
	input  logic signed [bfst_pkg::RSSI_W-1:0] signal_strength,
	input  logic [bfst_pkg::TIME_W-1:0]        time_ms,
	input  logic [bfst_pkg::ENTRY_W-1:0]       entry_index,
	// configuration channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bfst_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfst_pkg::CFG_DATA_W-1:0]    cfg_data,
	// result side
	output logic                               result_valid,
	output logic [bfst_pkg::SLOT_W-1:0]        slot_index,
	output logic [bfst_pkg::STATUS_W-1:0]      slot_status,
	output logic [bfst_pkg::ADDR_W-1:0]        out_address,
	output logic [bfst_pkg::UUID_W-1:0]        out_uuid_high,
	output logic [bfst_pkg::UUID_W-1:0]        out_uuid_low,
	output logic [bfst_pkg::ID_W-1:0]          out_major,
	output logic [bfst_pkg::ID_W-1:0]          out_minor,
	output logic signed [bfst_pkg::RSSI_W-1:0] out_strength,
	output logic [bfst_pkg::TIME_W-1:0]        last_seen
);

	bfst_pkg::dp_cmd_t  cmd;
	bfst_pkg::dp_stat_t stat;

	assign cfg_ready = !busy;

	bfst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	bfst_dp #(
		.SIGHT_SLOTS      (SIGHT_SLOTS),
		.ALLOW_ADDR_SLOTS (ALLOW_ADDR_SLOTS),
		.ALLOW_PAIR_SLOTS (ALLOW_PAIR_SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.device_address  (device_address),
		.uuid_high       (uuid_high),
		.uuid_low        (uuid_low),
		.major_id        (major_id),
		.minor_id        (minor_id),
		.signal_strength (signal_strength),
		.time_ms         (time_ms),
		.entry_index     (entry_index),
		.result_valid    (result_valid),
		.slot_index      (slot_index),
		.slot_status     (slot_status),
		.out_address     (out_address),
		.out_uuid_high   (out_uuid_high),
		.out_uuid_low    (out_uuid_low),
		.out_major       (out_major),
		.out_minor       (out_minor),
		.out_strength    (out_strength),
		.last_seen       (last_seen)
	);

endmodule

// File: rtl/bfst_chk.sv
// port level checks for the sighting table, bound to the top level
// depends on bfst_pkg and beacon_filter_sighting_table
module bfst_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic [bfst_pkg::FUNC_W-1:0]       func,
	input logic                              result_valid,
	input logic [bfst_pkg::SLOT_W-1:0]       slot_index,
	input logic [bfst_pkg::STATUS_W-1:0]     slot_status
);

	// a result is a single cycle strobe
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held two cycles");

	// the result shows once the block is free again
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result while busy");

	// allow writes and unused codes never occupy the block
	a_write_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func != bfst_pkg::FUNC_SIGHTING) |=> !busy)
		else $error("non sighting beat raised busy");

	// a sighting always occupies the block for its checks
	a_sight_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == bfst_pkg::FUNC_SIGHTING) |=> busy)
		else $error("sighting beat did not raise busy");

	// an overwrite always lands on slot zero
	a_overwrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && slot_status == bfst_pkg::ST_OVERWROTE) |-> slot_index == '0)
		else $error("overwrite outside slot zero");

endmodule

bind beacon_filter_sighting_table bfst_chk u_bfst_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.func         (func),
	.result_valid (result_valid),
	.slot_index   (slot_index),
	.slot_status  (slot_status)
);

// File: bench/tb_top.sv
// self-checking bench for the beacon accept list filter and sighting table
// depends on bfst_pkg and beacon_filter_sighting_table; predicts each record in-bench
// directed extremes first, then random phases with a new filter setup per phase
`timescale 1ns / 1ps

module tb_top;

	// widths and sizes from the package
	localparam int FUNC_W               = bfst_pkg::FUNC_W;
	localparam int ADDR_W               = bfst_pkg::ADDR_W;
	localparam int UUID_W               = bfst_pkg::UUID_W;
	localparam int ID_W                 = bfst_pkg::ID_W;
	localparam int RSSI_W               = bfst_pkg::RSSI_W;
	localparam int TIME_W               = bfst_pkg::TIME_W;
	localparam int ENTRY_W              = bfst_pkg::ENTRY_W;
	localparam int SLOT_W               = bfst_pkg::SLOT_W;
	localparam int STATUS_W             = bfst_pkg::STATUS_W;
	localparam int CNT_W                = bfst_pkg::CNT_W;
	localparam int CFG_IDX_W            = bfst_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W           = bfst_pkg::CFG_DATA_W;
	localparam int SIGHT_SLOTS_DEF      = bfst_pkg::SIGHT_SLOTS_DEF;
	localparam int ALLOW_ADDR_SLOTS_DEF = bfst_pkg::ALLOW_ADDR_SLOTS_DEF;
	localparam int ALLOW_PAIR_SLOTS_DEF = bfst_pkg::ALLOW_PAIR_SLOTS_DEF;

	// the func code the block leaves unused
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int POOL_SIZE      = 12;
	localparam int PHASES         = 10;
	localparam int BEATS_PER_PHASE = 140;
	localparam int SETTLE_CYCLES  = 40;

	typedef struct {
		logic [FUNC_W-1:0]        func;
		logic [ADDR_W-1:0]        addr;
		logic [UUID_W-1:0]        uuid_hi;
		logic [UUID_W-1:0]        uuid_lo;
		logic [ID_W-1:0]          major;
		logic [ID_W-1:0]          minor;
		logic signed [RSSI_W-1:0] rssi;
		logic [TIME_W-1:0]        stamp;
		logic [ENTRY_W-1:0]       entry;
	} beacon_beat_t;

	typedef struct {
		logic [SLOT_W-1:0]        slot;
		logic [STATUS_W-1:0]      status;
		logic [ADDR_W-1:0]        addr;
		logic [UUID_W-1:0]        uuid_hi;
		logic [UUID_W-1:0]        uuid_lo;
		logic [ID_W-1:0]          major;
		logic [ID_W-1:0]          minor;
		logic signed [RSSI_W-1:0] rssi;
		logic [TIME_W-1:0]        stamp;
	} sighting_record_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [FUNC_W-1:0]        func = '0;
	logic [ADDR_W-1:0]        device_address = '0;
	logic [UUID_W-1:0]        uuid_high = '0;
	logic [UUID_W-1:0]        uuid_low = '0;
	logic [ID_W-1:0]          major_id = '0;
	logic [ID_W-1:0]          minor_id = '0;
	logic signed [RSSI_W-1:0] signal_strength = '0;
	logic [TIME_W-1:0]        time_ms = '0;
	logic [ENTRY_W-1:0]       entry_index = '0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     result_valid;
	logic [SLOT_W-1:0]        slot_index;
	logic [STATUS_W-1:0]      slot_status;
	logic [ADDR_W-1:0]        out_address;
	logic [UUID_W-1:0]        out_uuid_high;
	logic [UUID_W-1:0]        out_uuid_low;
	logic [ID_W-1:0]          out_major;
	logic [ID_W-1:0]          out_minor;
	logic signed [RSSI_W-1:0] out_strength;
	logic [TIME_W-1:0]        last_seen;

	beacon_filter_sighting_table dut (.*);

	// beats waiting for the driver and records waiting for the block
	beacon_beat_t     pending_beats[$];
	sighting_record_t expected_records[$];
	int  beats_queued = 0;
	int  beats_taken = 0;
	bit  item_taken = 1'b0;
	bit  failed = 1'b0;

	// predictor copy of registers, allow lists and sighting table
	logic [UUID_W-1:0] filter_hi = '0;
	logic [UUID_W-1:0] filter_lo = '0;
	logic [CNT_W-1:0]  addr_count = '0;
	logic [CNT_W-1:0]  pair_count = '0;
	logic [ADDR_W-1:0] allow_addr[ALLOW_ADDR_SLOTS_DEF];
	logic [ID_W-1:0]   allow_major[ALLOW_PAIR_SLOTS_DEF];
	logic [ID_W-1:0]   allow_minor[ALLOW_PAIR_SLOTS_DEF];
	bit                slot_used[SIGHT_SLOTS_DEF];
	logic [ADDR_W-1:0] slot_addr[SIGHT_SLOTS_DEF];

	// stimulus side view of the filter and lists, kept ahead of the predictor
	logic [UUID_W-1:0] stim_filter_hi = '0;
	logic [UUID_W-1:0] stim_filter_lo = '0;
	logic [ADDR_W-1:0] stim_addr_list[ALLOW_ADDR_SLOTS_DEF];
	logic [ID_W-1:0]   stim_major_list[ALLOW_PAIR_SLOTS_DEF];
	logic [ID_W-1:0]   stim_minor_list[ALLOW_PAIR_SLOTS_DEF];
	logic [ADDR_W-1:0] addr_pool[POOL_SIZE];

	// sender burst state
	int burst_left = 8;
	int gap_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [ADDR_W-1:0] rand_addr();
		logic [63:0] v;
		v = rand64();
		return v[ADDR_W-1:0];
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			failed = 1'b1;
		end
	endtask

	task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			bfst_pkg::REG_UUID_HIGH:  filter_hi = data;
			bfst_pkg::REG_UUID_LOW:   filter_lo = data;
			bfst_pkg::REG_ADDR_COUNT: addr_count = data[CNT_W-1:0];
			bfst_pkg::REG_PAIR_COUNT: pair_count = data[CNT_W-1:0];
			default: ;
		endcase
	endtask

	// filter, allow lists and slot lookup for one accepted beat
	task automatic predict_beat(input beacon_beat_t b);
		sighting_record_t rec;
		int  i, hit, free_slot, na, np;
		bit  allowed;
		case (b.func)
			bfst_pkg::FUNC_ALLOW_ADDR: allow_addr[b.entry] = b.addr;
			bfst_pkg::FUNC_ALLOW_PAIR: begin
				allow_major[b.entry] = b.major;
				allow_minor[b.entry] = b.minor;
			end
			bfst_pkg::FUNC_SIGHTING: if (b.uuid_hi == filter_hi && b.uuid_lo == filter_lo) begin
				// counts above the list size saturate
				na = (addr_count > ALLOW_ADDR_SLOTS_DEF) ? ALLOW_ADDR_SLOTS_DEF : addr_count;
				np = (pair_count > ALLOW_PAIR_SLOTS_DEF) ? ALLOW_PAIR_SLOTS_DEF : pair_count;
				allowed = (na == 0 && np == 0);
				for (i = 0; i < na; i++)
					if (allow_addr[i] == b.addr)
						allowed = 1'b1;
				for (i = 0; i < np; i++)
					if (allow_major[i] == b.major && allow_minor[i] == b.minor)
						allowed = 1'b1;
				if (allowed) begin
					// matching slot, else first empty, else slot zero
					hit = -1;
					free_slot = -1;
					for (i = 0; i < SIGHT_SLOTS_DEF; i++) begin
						if (hit < 0 && slot_used[i] && slot_addr[i] == b.addr)
							hit = i;
						if (!slot_used[i] && free_slot < 0)
							free_slot = i;
					end
					if (hit >= 0) begin
						rec.status = bfst_pkg::ST_UPDATED;
					end else if (free_slot >= 0) begin
						hit = free_slot;
						rec.status = bfst_pkg::ST_FILLED;
					end else begin
						hit = 0;
						rec.status = bfst_pkg::ST_OVERWROTE;
					end
					slot_used[hit] = 1'b1;
					slot_addr[hit] = b.addr;
					rec.slot = hit[SLOT_W-1:0];
					rec.addr = b.addr;
					rec.uuid_hi = b.uuid_hi;
					rec.uuid_lo = b.uuid_lo;
					rec.major = b.major;
					rec.minor = b.minor;
					rec.rssi = b.rssi;
					rec.stamp = b.stamp;
					expected_records.push_back(rec);
				end
			end
			default: ;
		endcase
	endtask

	// driver: one beat per free slot, in bursts with random gaps
	always @(negedge clk) begin : driver
		beacon_beat_t b;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || item_taken) begin
			if (gap_left > 0 || pending_beats.size() == 0) begin
				start <= 1'b0;
				if (gap_left > 0)
					gap_left--;
			end else begin
				b = pending_beats.pop_front();
				start <= 1'b1;
				func <= b.func;
				device_address <= b.addr;
				uuid_high <= b.uuid_hi;
				uuid_low <= b.uuid_lo;
				major_id <= b.major;
				minor_id <= b.minor;
				signal_strength <= b.rssi;
				time_ms <= b.stamp;
				entry_index <= b.entry;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 35);
				end
			end
		end
	end

	// monitor: check records, track register writes, predict accepted beats
	always @(posedge clk) begin : monitor
		sighting_record_t want;
		beacon_beat_t b;
		if (!arst_n) begin
			item_taken = 1'b0;
		end else begin
			if (result_valid) begin
				if (expected_records.size() == 0) begin
					$error("record with no sighting pending: address %0h", out_address);
					failed = 1'b1;
				end else begin
					want = expected_records.pop_front();
					check_field("slot_index", 64'(want.slot), 64'(slot_index));
					check_field("slot_status", 64'(want.status), 64'(slot_status));
					check_field("out_address", 64'(want.addr), 64'(out_address));
					check_field("out_uuid_high", want.uuid_hi, out_uuid_high);
					check_field("out_uuid_low", want.uuid_lo, out_uuid_low);
					check_field("out_major", 64'(want.major), 64'(out_major));
					check_field("out_minor", 64'(want.minor), 64'(out_minor));
					check_field("out_strength", 64'(want.rssi), 64'(out_strength));
					check_field("last_seen", 64'(want.stamp), 64'(last_seen));
				end
			end
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			item_taken = start && !busy;
			if (item_taken) begin
				b.func = func;
				b.addr = device_address;
				b.uuid_hi = uuid_high;
				b.uuid_lo = uuid_low;
				b.major = major_id;
				b.minor = minor_id;
				b.rssi = signal_strength;
				b.stamp = time_ms;
				b.entry = entry_index;
				beats_taken++;
				predict_beat(b);
			end
		end
	end

	task automatic queue_beat(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
			input logic [UUID_W-1:0] uh, input logic [UUID_W-1:0] ul,
			input logic [ID_W-1:0] mj, input logic [ID_W-1:0] mn,
			input logic [RSSI_W-1:0] s, input logic [TIME_W-1:0] t,
			input logic [ENTRY_W-1:0] e);
		beacon_beat_t b;
		b.func = f;
		b.addr = a;
		b.uuid_hi = uh;
		b.uuid_lo = ul;
		b.major = mj;
		b.minor = mn;
		b.rssi = s;
		b.stamp = t;
		b.entry = e;
		pending_beats.push_back(b);
		beats_queued++;
		if (f == bfst_pkg::FUNC_ALLOW_ADDR)
			stim_addr_list[e] = a;
		if (f == bfst_pkg::FUNC_ALLOW_PAIR) begin
			stim_major_list[e] = mj;
			stim_minor_list[e] = mn;
		end
	endtask

	// mostly sightings aimed at the filter and lists, some list edits and noise
	task automatic queue_random_beat();
		int r, k;
		logic [ADDR_W-1:0] a;
		logic [UUID_W-1:0] uh, ul;
		logic [ID_W-1:0]   mj, mn;
		r = $urandom_range(99);
		a = rand_addr();
		uh = rand64();
		ul = rand64();
		mj = ID_W'($urandom());
		mn = ID_W'($urandom());
		if (r < 7) begin
			if ($urandom_range(2) != 0)
				a = addr_pool[$urandom_range(POOL_SIZE - 1)];
			queue_beat(bfst_pkg::FUNC_ALLOW_ADDR, a, uh, ul, mj, mn, RSSI_W'($urandom()),
				$urandom(), ENTRY_W'($urandom_range(7)));
		end else if (r < 14) begin
			queue_beat(bfst_pkg::FUNC_ALLOW_PAIR, a, uh, ul, mj, mn, RSSI_W'($urandom()),
				$urandom(), ENTRY_W'($urandom_range(7)));
		end else if (r < 16) begin
			queue_beat(FUNC_UNUSED, a, stim_filter_hi, stim_filter_lo, mj, mn,
				RSSI_W'($urandom()), $urandom(), ENTRY_W'($urandom_range(7)));
		end else begin
			k = $urandom_range(99);
			if (k < 55)
				a = addr_pool[$urandom_range(POOL_SIZE - 1)];
			else if (k < 75)
				a = stim_addr_list[$urandom_range(7)];
			if ($urandom_range(99) < 35) begin
				k = $urandom_range(7);
				mj = stim_major_list[k];
				mn = stim_minor_list[k];
			end
			// uuid: mostly a match, else half or single bit off, else random
			k = $urandom_range(99);
			if (k < 80) begin
				uh = stim_filter_hi;
				ul = stim_filter_lo;
			end else if (k < 86) begin
				uh = stim_filter_hi;
			end else if (k < 92) begin
				ul = stim_filter_lo;
			end else if (k < 96) begin
				uh = stim_filter_hi;
				ul = stim_filter_lo ^ (64'd1 << $urandom_range(63));
			end
			queue_beat(bfst_pkg::FUNC_SIGHTING, a, uh, ul, mj, mn, RSSI_W'($urandom()),
				$urandom(), ENTRY_W'($urandom_range(7)));
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// all four registers; junk above the count bits must be dropped
	task automatic configure(input logic [UUID_W-1:0] hi, input logic [UUID_W-1:0] lo,
			input logic [CNT_W-1:0] na, input logic [CNT_W-1:0] np);
		logic [63:0] junk_a, junk_p;
		junk_a = rand64();
		junk_p = rand64();
		write_reg(bfst_pkg::REG_UUID_HIGH, hi);
		write_reg(bfst_pkg::REG_UUID_LOW, lo);
		write_reg(bfst_pkg::REG_ADDR_COUNT, {junk_a[63:CNT_W], na});
		write_reg(bfst_pkg::REG_PAIR_COUNT, {junk_p[63:CNT_W], np});
		@(negedge clk);
		cfg_valid <= 1'b0;
		stim_filter_hi = hi;
		stim_filter_lo = lo;
	endtask

	// wait until every beat is taken and every record is in, then let walks finish
	task automatic wait_idle();
		int waited;
		waited = 0;
		do begin
			@(negedge clk);
			waited++;
		end while ((beats_taken != beats_queued || busy || expected_records.size() != 0)
			&& waited < 200000);
		if (expected_records.size() != 0) begin
			$error("%0d sightings never produced a record", expected_records.size());
			failed = 1'b1;
			expected_records.delete();
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		int i, p;
		logic [UUID_W-1:0] hi, lo;
		logic [CNT_W-1:0]  na, np;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = rand_addr();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fill both allow lists, extremes at the ends
		queue_beat(bfst_pkg::FUNC_ALLOW_ADDR, '0, rand64(), rand64(), '0, '0, '0, '0, '0);
		for (i = 1; i < 7; i++)
			queue_beat(bfst_pkg::FUNC_ALLOW_ADDR, addr_pool[i + 1], rand64(), rand64(),
				ID_W'($urandom()), ID_W'($urandom()), RSSI_W'($urandom()), $urandom(),
				ENTRY_W'(i));
		queue_beat(bfst_pkg::FUNC_ALLOW_ADDR, '1, '1, '1, '1, '1, '1, '1, ENTRY_W'(7));
		queue_beat(bfst_pkg::FUNC_ALLOW_PAIR, rand_addr(), rand64(), rand64(),
			16'h0000, 16'h0000, RSSI_W'($urandom()), $urandom(), '0);
		for (i = 1; i < 7; i++)
			queue_beat(bfst_pkg::FUNC_ALLOW_PAIR, rand_addr(), rand64(), rand64(),
				ID_W'($urandom()), ID_W'($urandom()), RSSI_W'($urandom()), $urandom(),
				ENTRY_W'(i));
		queue_beat(bfst_pkg::FUNC_ALLOW_PAIR, rand_addr(), rand64(), rand64(),
			16'hffff, 16'hffff, RSSI_W'($urandom()), $urandom(), ENTRY_W'(7));

		// directed sightings against the reset filter with empty lists
		queue_beat(bfst_pkg::FUNC_SIGHTING, '0, '0, '0, 16'h0000, 16'h0000, 8'h80, 32'h0,
			ENTRY_W'(0));
		queue_beat(bfst_pkg::FUNC_SIGHTING, '1, '0, '0, 16'hffff, 16'hffff, 8'h7f, '1,
			ENTRY_W'(7));
		queue_beat(bfst_pkg::FUNC_SIGHTING, '0, '0, '0, 16'h1234, 16'h5678, 8'h00, 32'h1,
			ENTRY_W'(3));
		queue_beat(bfst_pkg::FUNC_SIGHTING, addr_pool[2], '1, '0, 16'h1, 16'h2, 8'hc5,
			32'h10, ENTRY_W'(0));
		queue_beat(bfst_pkg::FUNC_SIGHTING, addr_pool[3], '0, '1, 16'h1, 16'h2, 8'hc5,
			32'h11, ENTRY_W'(0));
		queue_beat(FUNC_UNUSED, addr_pool[4], '0, '0, 16'h3, 16'h4, 8'hd0, 32'h12,
			ENTRY_W'(0));
		queue_beat(bfst_pkg::FUNC_SIGHTING, addr_pool[5], '0, '0, 16'h5, 16'h6, 8'hb0,
			32'h13, ENTRY_W'(5));
		wait_idle();

		// random phases, each with its own filter uuid and list counts
		for (p = 0; p < PHASES; p++) begin
			hi = rand64();
			lo = rand64();
			case (p)
				0: begin na = CNT_W'(0); np = CNT_W'(0); end
				1: begin na = CNT_W'(8); np = CNT_W'(8); end
				2: begin hi = '1; lo = '1; na = CNT_W'(15); np = CNT_W'(15); end
				3: begin na = CNT_W'(3); np = CNT_W'(0); end
				4: begin na = CNT_W'(0); np = CNT_W'(5); end
				5: begin hi = '0; lo = '0; na = CNT_W'(1); np = CNT_W'(1); end
				6: begin lo = '0; na = CNT_W'(9); np = CNT_W'(2); end
				7: begin
					na = CNT_W'($urandom_range(15));
					np = CNT_W'($urandom_range(15));
				end
				8: begin na = CNT_W'(8); np = CNT_W'(0); end
				default: begin na = CNT_W'(0); np = CNT_W'(8); end
			endcase
			configure(hi, lo, na, np);
			repeat (BEATS_PER_PHASE) queue_random_beat();
			wait_idle();
		end

		if (!failed)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/bfst_pkg.sv
rtl/bfst_ram.sv
rtl/bfst_ctrl.sv
rtl/bfst_dp.sv
rtl/beacon_filter_sighting_table.sv
rtl/bfst_chk.sv
bench/tb_top.sv
